// ----- src/frs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frs_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned READ_BYTES  = 6;
   localparam int unsigned IDX_W       = 4;

   localparam logic [7:0] CMD_WRITE  = 8'h57;  // 'W'
   localparam logic [7:0] CMD_READ   = 8'h52;  // 'R'
   localparam logic [7:0] BYTE_START = 8'h24;  // '$'
   localparam logic [7:0] BYTE_NL    = 8'h0A;  // newline

   localparam logic [IDX_W-1:0] COUNT_MAX     = 4'd15;
   localparam logic [IDX_W-1:0] WRITE_LAST_POS = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] READ_LAST_POS  = IDX_W'(READ_BYTES - 1);
   localparam logic [IDX_W-1:0] REPLY_LAST_IDX = IDX_W'(FRAME_BYTES - 1);
   localparam logic [IDX_W-1:0] REPLY_SUM_IDX  = IDX_W'(FRAME_BYTES - 2);

   localparam logic [1:0] ACT_NONE = 2'd0;

   localparam logic [2:0] CSR_SLAVE_ID  = 3'd0;
   localparam logic [2:0] CSR_WORD_ZERO = 3'd1;
   localparam logic [2:0] CSR_WORD_ONE  = 3'd2;
   localparam logic [2:0] CSR_WORD_TWO  = 3'd3;
   localparam logic [2:0] CSR_WORD_THREE = 3'd4;

   localparam logic [7:0] SLAVE_ID_RESET = 8'd1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0]         tx_byte;
      logic               reply_last;
      logic [1:0]         action;
      logic signed [31:0] action_value;
   } rsp_type;

   typedef struct packed {
      logic [7:0]      own_slave_id;
      logic [3:0][7:0] read_word;
   } cfg_type;

   // One accepted frame, as the serialiser needs it.
   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  cmd;
      logic [7:0]  addr;
      logic [31:0] data;
      logic [1:0]  action;
   } reply_type;

   typedef struct packed {
      logic push;
      logic pop;
   } qctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ----- src/frs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frs_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire frs_pkg::req_type    req,
   input  wire frs_pkg::cfg_type    cfg,
   output      logic                push,
   output      frs_pkg::reply_type  reply
);

   logic [frs_pkg::IDX_W-1:0] count_ff, count_in;
   logic [7:0]                short_sum_ff, short_sum_in;
   logic [7:0]                long_sum_ff, long_sum_in;
   logic [7:0]                store_ff [0:7];
   logic [2:0]                store_idx;
   logic                      store_en;
   logic                      write_ok, read_ok;
   logic                      in_short, in_long;

   assign in_short  = (count_ff >= 4'd1) && (count_ff <= 4'd3);
   assign in_long   = (count_ff >= 4'd1) && (count_ff <= 4'd7);
   assign store_en  = accept && (count_ff >= 4'd1) && (count_ff <= 4'd8);
   assign store_idx = 3'(count_ff - 4'd1);

   always_comb begin
      count_in     = count_ff;
      short_sum_in = short_sum_ff;
      long_sum_in  = long_sum_ff;
      if (accept) begin
         if (req.frame_end) begin
            count_in     = '0;
            short_sum_in = '0;
            long_sum_in  = '0;
         end else begin
            if (count_ff != frs_pkg::COUNT_MAX) begin
               count_in = count_ff + 4'd1;
            end
            if (in_short) begin
               short_sum_in = short_sum_ff + req.rx_byte;
            end
            if (in_long) begin
               long_sum_in = long_sum_ff + req.rx_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         short_sum_ff <= '0;
         long_sum_ff  <= '0;
      end else begin
         count_ff     <= count_in;
         short_sum_ff <= short_sum_in;
         long_sum_ff  <= long_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         store_ff[store_idx] <= req.rx_byte;
      end
   end

   // Only a frame of the right length can pass, and for those lengths every
   // byte the checks use has already been stored, as have both sums.
   assign write_ok = (store_ff[1] == frs_pkg::CMD_WRITE)
                  && (count_ff == frs_pkg::WRITE_LAST_POS)
                  && (long_sum_ff == store_ff[7]);
   assign read_ok  = (store_ff[1] == frs_pkg::CMD_READ)
                  && (count_ff == frs_pkg::READ_LAST_POS)
                  && (short_sum_ff == store_ff[3]);

   assign push = accept && req.frame_end && (store_ff[0] == cfg.own_slave_id)
              && (write_ok || read_ok);

   always_comb begin
      reply.id     = store_ff[0];
      reply.cmd    = store_ff[1];
      reply.addr   = store_ff[2];
      reply.action = frs_pkg::ACT_NONE;
      if (store_ff[1] == frs_pkg::CMD_WRITE) begin
         reply.data = {store_ff[3], store_ff[4], store_ff[5], store_ff[6]};
         if ((store_ff[2] >= 8'd1) && (store_ff[2] <= 8'd3)) begin
            reply.action = store_ff[2][1:0];
         end
      end else if (store_ff[2] < 8'd4) begin
         reply.data = {24'd0, cfg.read_word[store_ff[2][1:0]]};
      end else begin
         reply.data = '0;
      end
   end

endmodule

`default_nettype wire

// ----- src/frs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frs_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire frs_pkg::qctl_type  ctl,
   input  wire frs_pkg::reply_type wr_data,
   output      frs_pkg::qstat_type stat,
   output      frs_pkg::reply_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   frs_pkg::reply_type entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign stat.full  = (fill_ff == CNT_FULL);
   assign stat.empty = (fill_ff == '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/frs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire frs_pkg::reply_type head,
   input  wire logic               head_valid,
   output      logic               head_pop,
   input  wire logic               rsp_pop,
   output      logic               rsp_empty,
   output      frs_pkg::rsp_type   rsp_data
);

   logic [frs_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]                sum_ff, sum_in;
   logic                      out_valid_ff, out_valid_in;
   frs_pkg::rsp_type          out_ff;
   frs_pkg::rsp_type          next_rsp;
   logic                      advance;
   logic [7:0]                cur_byte;

   assign advance   = head_valid && (!out_valid_ff || rsp_pop);
   assign head_pop  = advance && (idx_ff == frs_pkg::REPLY_LAST_IDX);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      case (idx_ff)
         4'd0:    cur_byte = frs_pkg::BYTE_START;
         4'd1:    cur_byte = head.id;
         4'd2:    cur_byte = head.cmd;
         4'd3:    cur_byte = head.addr;
         4'd4:    cur_byte = head.data[31:24];
         4'd5:    cur_byte = head.data[23:16];
         4'd6:    cur_byte = head.data[15:8];
         4'd7:    cur_byte = head.data[7:0];
         4'd8:    cur_byte = sum_ff;
         default: cur_byte = frs_pkg::BYTE_NL;
      endcase
   end

   always_comb begin
      next_rsp.tx_byte      = cur_byte;
      next_rsp.reply_last   = (idx_ff == frs_pkg::REPLY_LAST_IDX);
      next_rsp.action       = frs_pkg::ACT_NONE;
      next_rsp.action_value = '0;
      if ((idx_ff == '0) && (head.action != frs_pkg::ACT_NONE)) begin
         next_rsp.action       = head.action;
         next_rsp.action_value = head.data;
      end
   end

   // The checksum builds up as bytes one to seven go out.
   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in = 1'b1;
         idx_in = (idx_ff == frs_pkg::REPLY_LAST_IDX) ? '0 : idx_ff + 4'd1;
         if (idx_ff == '0) begin
            sum_in = '0;
         end else if (idx_ff < frs_pkg::REPLY_SUM_IDX) begin
            sum_in = sum_ff + cur_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= next_rsp;
      end
   end

endmodule

`default_nettype wire

// ----- src/framed_register_slave_responder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Framed register slave: frame bytes are pushed one per request, with
// frame_end on the last, and each frame that carries this slave's id, a
// known command, the right length and a good checksum is answered with a
// ten-byte reply read from the result queue, the first byte of a write
// also carrying any setpoint or stop-all action. The front end absorbs one
// request every cycle while the queue is not full; a good frame's reply is
// placed in a queue of QUEUE_DEPTH entries and the serialiser drains it at
// one byte per cycle, while rsp_pop takes each byte, through a registered
// output. Input therefore runs at one request per cycle while the replies
// keep pace; a run of good six-byte reads outpaces their ten-byte replies,
// so the queue fills, and full rises only while the reply queue is full.
// With the serialiser idle, a reply's first byte passes through the queue
// entry and then the output register before it is shown. Configuration
// writes are always ready and should be made while no frame is in flight.
module framed_register_slave_responder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire frs_pkg::req_type req_data,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      frs_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [7:0]       csr_data
);

   frs_pkg::cfg_type   cfg_ff;
   frs_pkg::reply_type front_reply;
   frs_pkg::reply_type head;
   frs_pkg::qctl_type  qctl;
   frs_pkg::qstat_type qstat;
   logic               req_accept;
   logic               front_push;
   logic               head_pop;

   assign csr_ready  = 1'b1;
   assign req_full   = qstat.full;
   assign req_accept = req_push && !qstat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_slave_id <= frs_pkg::SLAVE_ID_RESET;
         cfg_ff.read_word    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            frs_pkg::CSR_SLAVE_ID:   cfg_ff.own_slave_id <= csr_data;
            frs_pkg::CSR_WORD_ZERO:  cfg_ff.read_word[0] <= csr_data;
            frs_pkg::CSR_WORD_ONE:   cfg_ff.read_word[1] <= csr_data;
            frs_pkg::CSR_WORD_TWO:   cfg_ff.read_word[2] <= csr_data;
            frs_pkg::CSR_WORD_THREE: cfg_ff.read_word[3] <= csr_data;
            default: ;
         endcase
      end
   end

   frs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .push   (front_push),
      .reply  (front_reply)
   );

   assign qctl = '{push: front_push, pop: head_pop};

   frs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qctl),
      .wr_data (front_reply),
      .stat    (qstat),
      .head    (head)
   );

   frs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!qstat.empty),
      .head_pop   (head_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- src/frs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module frs_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire frs_pkg::rsp_type rsp_data
);

   // A result left waiting stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting reply byte changed or vanished");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("reply queue not empty after reset");

   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.reply_last) |-> (rsp_data.tx_byte == frs_pkg::BYTE_NL))
      else $error("final reply byte is not a newline");

   // After a reply's last byte, the next one shown must open a new reply.
   a_next_starts: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.reply_last)
      |=> (rsp_empty || (rsp_data.tx_byte == frs_pkg::BYTE_START)))
      else $error("reply does not start with the start byte");

   a_action_first: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.action != frs_pkg::ACT_NONE))
      |-> ((rsp_data.tx_byte == frs_pkg::BYTE_START) && !rsp_data.reply_last))
      else $error("action shown away from the first reply byte");

endmodule

bind framed_register_slave_responder frs_checker u_frs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
